[hdl/udf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udf_pkg: shared types and constants of the UART frame deframer
// Command and status codes, frame constants, register indexes and the
// classified-command word that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package udf_pkg;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_TAKEN     = 3'd1,
    ST_READY     = 3'd2,
    ST_SUM_ERR   = 3'd3,
    ST_TIMEOUT   = 3'd4,
    ST_DROPPED   = 3'd5,
    ST_OVERFLOW  = 3'd6,
    ST_READ_DONE = 3'd7
  } status_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_CHECKSUM_ENABLE = 1'b0,
    REG_TIMEOUT_TICKS   = 1'b1
  } reg_e;

  localparam logic       CSUM_EN_RESET = 1'b1;
  localparam logic [7:0] TIMEOUT_RESET = 8'd10;

  // Frame delimiters; the tail is sent in index order 0..3.
  localparam logic [7:0]      HEADER_BYTE = 8'hAA;
  localparam logic [3:0][7:0] TAIL_BYTES  = {8'h3C, 8'hC3, 8'h33, 8'hCC};
  localparam int              TAIL_LEN    = 4;

  // Checksum framing: two sum bytes plus the tail follow the payload.
  localparam int CSUM_MIN_LEN = 6;
  localparam int SUM_DEPTH    = 7;
  // History of previously stored bytes; tap 0 is the newest. When the last
  // tail byte arrives, the sum high and low bytes sit at these taps.
  localparam int HIST_DEPTH   = 5;
  localparam int CSUM_HI_TAP  = 4;
  localparam int CSUM_LO_TAP  = 3;

  // Queue depths between the parts.
  localparam int CMD_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 4;

  // Classified command word.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] rx_byte;
    logic       is_header;
    logic [3:0] tail_hit;
    logic [7:0] read_index;
    logic       read_ok;
  } udf_op_t;

endpackage

[hdl/udf_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udf_fifo: small register queue
// A first-in first-out queue of words in flip-flops, with a fill level.
// ----------------------------------------------------------------------------
module udf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [LW-1:0]    level_q, level_d;
  logic             do_push, do_pop;

  assign full_o  = (level_q == LW'(DEPTH));
  assign empty_o = (level_q == '0);
  assign level_o = level_q;
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and level update.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    level_d = level_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH-1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH-1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      level_d = level_q + LW'(1);
    end else if (do_pop && !do_push) begin
      level_d = level_q - LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      level_q <= level_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LW'(DEPTH))
    else $error("queue level beyond depth");

endmodule

[hdl/udf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udf_front: command classifier
// Decodes an incoming word and precomputes the byte matches and the read
// range check that the back end needs.
// ----------------------------------------------------------------------------
module udf_front #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic [1:0]       cmd_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [7:0]       read_index_i,
  output udf_pkg::udf_op_t op_o
);
  import udf_pkg::*;

  // Header and tail byte matches, read position check.
  always_comb begin
    op_o.cmd        = cmd_e'(cmd_i);
    op_o.rx_byte    = rx_byte_i;
    op_o.is_header  = (rx_byte_i == HEADER_BYTE);
    for (int k = 0; k < TAIL_LEN; k++) begin
      op_o.tail_hit[k] = (rx_byte_i == TAIL_BYTES[k]);
    end
    op_o.read_index = read_index_i;
    op_o.read_ok    = (32'(read_index_i) < BUFFER_DEPTH);
  end

endmodule

[hdl/udf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udf_back: frame engine
// Executes one classified word per cycle while res_room_i is high: frame
// state, tail matcher, running-sum delay line, frame buffer, result stage.
// ----------------------------------------------------------------------------
module udf_back #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  checksum_enable_i,
  input  logic [7:0]                            timeout_ticks_i,
  input  logic                                  op_valid_i,
  input  udf_pkg::udf_op_t                      op_i,
  input  logic                                  res_room_i,
  output logic                                  op_pop_o,
  output logic                                  res_valid_o,
  output udf_pkg::status_e                      res_status_o,
  output logic                                  res_frame_ready_o,
  output logic [$clog2(BUFFER_DEPTH+1)-1:0]     res_length_o,
  output logic [7:0]                            res_data_o
);
  import udf_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH+1);

  logic          in_frame_q, in_frame_d;
  logic [2:0]    tmc_q, tmc_d, tail_next;
  logic [CW-1:0] bc_q, bc_d, n_len;
  logic          pend_q, pend_d;
  logic [7:0]    idle_q, idle_d, idle_inc;
  logic [15:0]   sum_q [SUM_DEPTH];
  logic [15:0]   sum_d [SUM_DEPTH];
  logic [7:0]    hist_q [HIST_DEPTH];
  logic [7:0]    hist_d [HIST_DEPTH];
  logic          issue, mem_we, sum_match;
  status_e       status;

  logic [7:0]    mem_q [BUFFER_DEPTH];
  logic [7:0]    rdata_q;

  logic          w_valid_q;
  status_e       w_status_q;
  logic          w_ready_q;
  logic [CW-1:0] w_len_q;
  logic          w_rd_ok_q;

  assign issue    = op_valid_i && res_room_i;
  assign op_pop_o = issue;
  assign n_len    = bc_q + CW'(1);
  assign idle_inc = (idle_q != 8'hFF) ? idle_q + 8'd1 : idle_q;
  assign sum_match = ({hist_q[CSUM_HI_TAP], hist_q[CSUM_LO_TAP]} == sum_q[SUM_DEPTH-2]);

  // Tail matcher: advance on the expected byte, restart on the first one.
  always_comb begin
    tail_next = tmc_q;
    if (tmc_q >= 3'd1 && tmc_q <= 3'd3) begin
      tail_next = op_i.tail_hit[tmc_q[1:0]] ? tmc_q + 3'd1 : 3'd0;
    end
    if (tail_next == 3'd0 && op_i.tail_hit[0]) begin
      tail_next = 3'd1;
    end
  end

  // Frame state update for the word being executed.
  always_comb begin
    in_frame_d = in_frame_q;
    tmc_d      = tmc_q;
    bc_d       = bc_q;
    pend_d     = pend_q;
    idle_d     = idle_q;
    sum_d      = sum_q;
    hist_d     = hist_q;
    mem_we     = 1'b0;
    status     = ST_IDLE;
    if (issue) begin
      case (op_i.cmd)
        CMD_BYTE: begin
          if (pend_q) begin
            status = ST_DROPPED;
          end else begin
            idle_d = '0;
            if (!in_frame_q) begin
              if (op_i.is_header) begin
                in_frame_d = 1'b1;
                tmc_d      = '0;
                bc_d       = '0;
                for (int j = 0; j < SUM_DEPTH; j++) begin
                  sum_d[j] = '0;
                end
                status = ST_TAKEN;
              end
            end else if (bc_q >= CW'(BUFFER_DEPTH)) begin
              in_frame_d = 1'b0;
              tmc_d      = '0;
              bc_d       = '0;
              status     = ST_OVERFLOW;
            end else begin
              mem_we = 1'b1;
              bc_d   = n_len;
              for (int j = 1; j < SUM_DEPTH; j++) begin
                sum_d[j] = sum_q[j-1];
              end
              sum_d[0] = sum_q[0] + {8'h00, op_i.rx_byte};
              for (int j = 1; j < HIST_DEPTH; j++) begin
                hist_d[j] = hist_q[j-1];
              end
              hist_d[0] = op_i.rx_byte;
              tmc_d     = tail_next;
              status    = ST_TAKEN;
              // Whole tail seen: close the frame and check it.
              if (tail_next == 3'(TAIL_LEN)) begin
                in_frame_d = 1'b0;
                tmc_d      = '0;
                if (!checksum_enable_i) begin
                  pend_d = 1'b1;
                  bc_d   = n_len - CW'(TAIL_LEN);
                  status = ST_READY;
                end else if (n_len >= CW'(CSUM_MIN_LEN) && sum_match) begin
                  pend_d = 1'b1;
                  bc_d   = n_len - CW'(CSUM_MIN_LEN);
                  status = ST_READY;
                end else begin
                  bc_d   = '0;
                  status = ST_SUM_ERR;
                end
              end
            end
          end
        end
        CMD_TICK: begin
          if (in_frame_q) begin
            idle_d = idle_inc;
            if (idle_inc >= timeout_ticks_i) begin
              in_frame_d = 1'b0;
              tmc_d      = '0;
              bc_d       = '0;
              idle_d     = '0;
              status     = ST_TIMEOUT;
            end
          end
        end
        CMD_READ: begin
          status = ST_READ_DONE;
        end
        CMD_RELEASE: begin
          if (pend_q) begin
            pend_d = 1'b0;
            bc_d   = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      tmc_q      <= '0;
      bc_q       <= '0;
      pend_q     <= 1'b0;
      idle_q     <= '0;
      w_valid_q  <= 1'b0;
      for (int j = 0; j < SUM_DEPTH; j++) begin
        sum_q[j] <= '0;
      end
    end else begin
      in_frame_q <= in_frame_d;
      tmc_q      <= tmc_d;
      bc_q       <= bc_d;
      pend_q     <= pend_d;
      idle_q     <= idle_d;
      w_valid_q  <= issue;
      sum_q      <= sum_d;
    end
  end

  // Byte history and result stage payload.
  always_ff @(posedge clk_i) begin
    hist_q     <= hist_d;
    w_status_q <= status;
    w_ready_q  <= pend_d;
    w_len_q    <= pend_d ? bc_d : '0;
    w_rd_ok_q  <= issue && (op_i.cmd == CMD_READ) && op_i.read_ok;
  end

  // Frame buffer: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[bc_q[AW-1:0]] <= op_i.rx_byte;
    end
    if (issue && op_i.cmd == CMD_READ && op_i.read_ok) begin
      rdata_q <= mem_q[AW'(op_i.read_index)];
    end
  end

  assign res_valid_o       = w_valid_q;
  assign res_status_o      = w_status_q;
  assign res_frame_ready_o = w_ready_q;
  assign res_length_o      = w_len_q;
  assign res_data_o        = w_rd_ok_q ? rdata_q : 8'h00;

  a_pend_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_frame_q && pend_q))
    else $error("frame open while another frame is pending");

  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tmc_q <= 3'd3)
    else $error("tail matcher left past a complete tail");

  a_ready_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (w_valid_q && w_status_q == ST_READY) |-> w_ready_q)
    else $error("frame reported ready without a pending frame");

endmodule

[hdl/uart_frame_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_frame_deframer: byte-stream deframer with header, tail and sum16
// Top level: configuration registers, front end, command queue, frame
// engine and result queue.
// ----------------------------------------------------------------------------
// Usage:
// Words enter through a queue-style port: a word (cmd_i, rx_byte_i,
// read_index_i) is taken at a clock edge with push high and full low.
// Each word yields exactly one result word, delivered in order on
// status_o, frame_ready_o, payload_length_o and read_data_o while empty is
// low, and taken at an edge with pop high.
// Throughput is one word per cycle while the result queue has room; the
// frame engine then retires one word per cycle, and its frame buffer, with
// one write port and one registered read port, serves either a stored byte
// or a payload read. A two-entry command queue and a four-entry result queue
// let the sides stall independently; when pop stays low the result queue
// fills, the engine stops, and full rises once the command queue is full too.
// Reset empties both queues, closes any frame, drops a pending frame and
// loads checksum_enable = 1 and timeout_ticks = 10. The frame buffer is not
// cleared; entries not written since reset must not be read.
// Registers (APB, byte address 4*i): 0 checksum_enable, 1 timeout_ticks.
// ----------------------------------------------------------------------------
module uart_frame_deframer #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Command queue side
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        cmd_i,
  input  logic [7:0]                        rx_byte_i,
  input  logic [7:0]                        read_index_i,
  // Result queue side
  output logic                              empty,
  input  logic                              pop,
  output logic [2:0]                        status_o,
  output logic                              frame_ready_o,
  output logic [$clog2(BUFFER_DEPTH+1)-1:0] payload_length_o,
  output logic [7:0]                        read_data_o,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import udf_pkg::*;

  localparam int CW     = $clog2(BUFFER_DEPTH+1);
  localparam int RW     = 3 + 1 + CW + 8;
  localparam int OPW    = $bits(udf_op_t);
  localparam int RES_LW = $clog2(RES_Q_DEPTH+1);
  localparam int CMD_LW = $clog2(CMD_Q_DEPTH+1);

  logic          csum_en_q;
  logic [7:0]    timeout_q;
  reg_e          reg_sel;
  logic          cfg_write;

  udf_op_t       op_in, op_out;
  logic [OPW-1:0] op_rdata;
  logic          cmd_empty, op_pop;
  logic [CMD_LW-1:0] cmd_level;

  logic          res_valid, res_ready, res_room, res_full;
  status_e       res_status;
  logic [CW-1:0] res_len;
  logic [7:0]    res_data;
  logic [RW-1:0] res_wdata, res_rdata;
  logic [RES_LW-1:0] res_level;

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_sel   = reg_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csum_en_q <= CSUM_EN_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_CHECKSUM_ENABLE: csum_en_q <= pwdata[0];
        REG_TIMEOUT_TICKS:   timeout_q <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CHECKSUM_ENABLE: prdata = {31'd0, csum_en_q};
      REG_TIMEOUT_TICKS:   prdata = {24'd0, timeout_q};
      default:             prdata = '0;
    endcase
  end

  // Front end and command queue.
  udf_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .cmd_i        (cmd_i),
    .rx_byte_i    (rx_byte_i),
    .read_index_i (read_index_i),
    .op_o         (op_in)
  );

  udf_fifo #(
    .WIDTH(OPW),
    .DEPTH(CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (op_in),
    .full_o  (full),
    .pop_i   (op_pop),
    .rdata_o (op_rdata),
    .empty_o (cmd_empty),
    .level_o (cmd_level)
  );

  assign op_out = udf_op_t'(op_rdata);

  // Keep one result slot free for the word in the result stage.
  assign res_room = (res_level < RES_LW'(RES_Q_DEPTH - 1)) && (cmd_level != '0);

  udf_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .checksum_enable_i (csum_en_q),
    .timeout_ticks_i   (timeout_q),
    .op_valid_i        (!cmd_empty),
    .op_i              (op_out),
    .res_room_i        (res_room),
    .op_pop_o          (op_pop),
    .res_valid_o       (res_valid),
    .res_status_o      (res_status),
    .res_frame_ready_o (res_ready),
    .res_length_o      (res_len),
    .res_data_o        (res_data)
  );

  // Result queue.
  assign res_wdata = {res_status, res_ready, res_len, res_data};

  udf_fifo #(
    .WIDTH(RW),
    .DEPTH(RES_Q_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .wdata_i (res_wdata),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty),
    .level_o (res_level)
  );

  assign status_o         = res_rdata[RW-1 -: 3];
  assign frame_ready_o    = res_rdata[CW+8];
  assign payload_length_o = res_rdata[CW+7 -: CW];
  assign read_data_o      = res_rdata[7:0];

  a_res_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !res_full)
    else $error("result word arrived at a full result queue");

  a_pop_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop |-> !cmd_empty)
    else $error("engine took a word from an empty command queue");

endmodule
